// ----- sv/vector_rotate_to_direction_core_macros.svh -----
// Assertion macros for the vector rotate-to-direction core.
`ifndef VECTOR_ROTATE_TO_DIRECTION_CORE_MACROS_SVH
`define VECTOR_ROTATE_TO_DIRECTION_CORE_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define VRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define VRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/vrd_pkg.sv -----
// Shared types and constants for the vector rotate-to-direction core.
package vrd_pkg;

    localparam int ACC_W            = 64;
    localparam int DATA_WIDTH_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int MAX_STEPS        = 40;
    localparam int UNSCALE_LAT      = 3;
    localparam int GAIN_W           = 30;
    // 1/K of the CORDIC, unsigned Q0.30
    localparam logic [GAIN_W-1:0] GAIN_INV_Q30 = 30'd652032874;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic                 axis;   // direction on the z axis
        logic                 xneg;
        logic                 zneg;
        t_acc                 zabs;
        t_acc                 px;
        t_acc                 py;
        t_acc                 pz;
        t_acc                 pzr;    // z after the tilt rotation
        logic [MAX_STEPS-1:0] dirs;   // azimuth micro-rotation directions
    } t_ctx;

endpackage

// ----- sv/vrd_cordic_step.sv -----
// One registered CORDIC micro-rotation on a pair and a carried vector.
module vrd_cordic_step #(
    parameter int SHIFT   = 0,
    parameter bit USE_DIR = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  vrd_pkg::t_acc i_a,
    input  vrd_pkg::t_acc i_b,
    input  vrd_pkg::t_acc i_u,
    input  vrd_pkg::t_acc i_v,
    input  logic          i_dir,
    output vrd_pkg::t_acc o_a,
    output vrd_pkg::t_acc o_b,
    output vrd_pkg::t_acc o_u,
    output vrd_pkg::t_acc o_v
);
    import vrd_pkg::*;

    t_acc r_a, r_b, r_u, r_v;
    t_acc n_a, n_b, n_u, n_v;
    t_acc sa, sb, su, sv;
    logic cw;

    // clockwise when b is non-negative, or as replayed from an earlier pass
    assign cw = USE_DIR ? i_dir : ~i_b[ACC_W-1];
    assign sa = i_a >>> SHIFT;
    assign sb = i_b >>> SHIFT;
    assign su = i_u >>> SHIFT;
    assign sv = i_v >>> SHIFT;

    always_comb begin
        if (cw) begin
            n_a = i_a + sb;
            n_b = i_b - sa;
            n_u = i_u + sv;
            n_v = i_v - su;
        end else begin
            n_a = i_a - sb;
            n_b = i_b + sa;
            n_u = i_u - sv;
            n_v = i_v + su;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_u <= n_u;
            r_v <= n_v;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_u = r_u;
    assign o_v = r_v;
endmodule

// ----- sv/vrd_unscale.sv -----
// Three-stage CORDIC gain correction, rounding half away from zero.
module vrd_unscale (
    input  logic          i_clk,
    input  logic          i_en,
    input  vrd_pkg::t_acc i_val,
    output vrd_pkg::t_acc o_val
);
    import vrd_pkg::*;

    localparam int HALF_W = ACC_W / 2;
    localparam int PROD_W = HALF_W + GAIN_W;

    logic                r_neg1, r_neg2;
    logic [ACC_W-1:0]    r_mag;
    logic [PROD_W-1:0]   r_hi_p, r_lo_p;
    t_acc                r_out;
    logic [ACC_W-1:0]    n_sum;

    always_comb begin
        n_sum = (ACC_W'(r_hi_p) << 2)
              + ACC_W'((ACC_W'(r_lo_p) + (ACC_W'(1) << (GAIN_W - 1))) >> GAIN_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_val[ACC_W-1];
            r_mag  <= i_val[ACC_W-1] ? ACC_W'(-i_val) : ACC_W'(i_val);
            r_neg2 <= r_neg1;
            r_hi_p <= PROD_W'(r_mag[ACC_W-1:HALF_W]) * PROD_W'(GAIN_INV_Q30);
            r_lo_p <= PROD_W'(r_mag[HALF_W-1:0]) * PROD_W'(GAIN_INV_Q30);
            r_out  <= r_neg2 ? -t_acc'(n_sum) : t_acc'(n_sum);
        end
    end

    assign o_val = r_out;
endmodule

// ----- sv/vector_rotate_to_direction_core.sv -----
// Top level: pipelined rotation of a vector onto a direction with three CORDIC passes.
//
//  port group  | dir | contents
//  i_s_*       | in  | dir_x, dir_y, dir_z, vec_x, vec_y, vec_z
//  o_m_*       | out | rot_x, rot_y, rot_z
//
// One transaction enters per cycle while the output is not stalled; the pipeline is
// three chains of CORDIC_STEPS registered micro-rotations plus gain correction.
// Reset clears only the valid bits; payload registers are not reset.
// A stall at the output freezes the whole pipeline; o_s_tready drops in the same cycle.
module vector_rotate_to_direction_core #(
    parameter int  DATA_WIDTH   = vrd_pkg::DATA_WIDTH_DEF,
    parameter int  CORDIC_STEPS = vrd_pkg::CORDIC_STEPS_DEF,
    localparam int IN_W  = ((6 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // dir_x, dir_y, dir_z, vec_x, vec_y, vec_z (lowest first), zero padded
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // rot_x, rot_y, rot_z (lowest first), zero padded
    output logic [OUT_W-1:0] o_m_tdata
);
    import vrd_pkg::*;

    `include "vector_rotate_to_direction_core_macros.svh"

    localparam int N     = CORDIC_STEPS;
    localparam int GUARD = ACC_W - 4 - DATA_WIDTH;
    localparam int P2    = N + UNSCALE_LAT + 1;
    localparam int P3    = 2 * N + 2 * UNSCALE_LAT + 2;
    localparam int TOT   = 3 * N + 3 * UNSCALE_LAT + 4;
    localparam t_acc Q_MAX = (t_acc'(1) <<< (DATA_WIDTH - 1)) - t_acc'(1);
    localparam t_acc Q_MIN = -Q_MAX - t_acc'(1);

    function automatic logic [DATA_WIDTH-1:0] f_narrow(input t_acc v);
        t_acc q;
        q = (v + (t_acc'(1) <<< (GUARD - 1))) >>> GUARD;
        if (q > Q_MAX) q = Q_MAX;
        if (q < Q_MIN) q = Q_MIN;
        return q[DATA_WIDTH-1:0];
    endfunction

    logic           en;
    logic [TOT-1:0] r_vld;
    t_ctx           r_ctx [TOT];
    t_ctx           n_ctx [TOT];

    t_acc c1_a [N+1], c1_b [N+1], c1_u [N+1], c1_v [N+1];
    t_acc c2_a [N+1], c2_b [N+1], c2_u [N+1], c2_v [N+1];
    t_acc c3_a [N+1], c3_b [N+1], c3_u [N+1], c3_v [N+1];
    t_acc u1_r, u2_u, u2_v, u3_u, u3_v;

    t_acc r_a0, r_b0;
    t_acc r_p2_a, r_p2_b, r_p2_u, r_p2_v;
    t_acc r_p3_u, r_p3_v;
    logic [OUT_W-1:0] r_out;

    // input field decode
    t_acc in_x, in_y, in_z, in_px, in_py, in_pz;
    logic in_xneg, in_zneg;

    assign en         = ~r_vld[TOT-1] | i_m_tready;
    assign o_s_tready = en;

    assign in_x  = t_acc'($signed(i_s_tdata[0*DATA_WIDTH +: DATA_WIDTH])) <<< GUARD;
    assign in_y  = t_acc'($signed(i_s_tdata[1*DATA_WIDTH +: DATA_WIDTH])) <<< GUARD;
    assign in_z  = t_acc'($signed(i_s_tdata[2*DATA_WIDTH +: DATA_WIDTH])) <<< GUARD;
    assign in_px = t_acc'($signed(i_s_tdata[3*DATA_WIDTH +: DATA_WIDTH])) <<< GUARD;
    assign in_py = t_acc'($signed(i_s_tdata[4*DATA_WIDTH +: DATA_WIDTH])) <<< GUARD;
    assign in_pz = t_acc'($signed(i_s_tdata[5*DATA_WIDTH +: DATA_WIDTH])) <<< GUARD;
    assign in_xneg = in_x[ACC_W-1];
    assign in_zneg = in_z[ACC_W-1];

    always_comb begin
        n_ctx[0].axis = (in_x == '0) && (in_y == '0);
        n_ctx[0].xneg = in_xneg;
        n_ctx[0].zneg = in_zneg;
        n_ctx[0].zabs = in_zneg ? -in_z : in_z;
        n_ctx[0].px   = in_px;
        n_ctx[0].py   = in_py;
        n_ctx[0].pz   = in_pz;
        n_ctx[0].pzr  = '0;
        n_ctx[0].dirs = '0;
    end

    // context travels with the data; the azimuth directions and tilted z are filled in on the way
    for (genvar k = 1; k < TOT; k++) begin : g_ctx
        if (k <= N) begin : g_dir
            always_comb begin
                n_ctx[k] = r_ctx[k-1];
                n_ctx[k].dirs[k-1] = ~c1_b[k-1][ACC_W-1];
            end
        end else if (k == P3) begin : g_pzr
            always_comb begin
                n_ctx[k] = r_ctx[k-1];
                n_ctx[k].pzr = u2_v;
            end
        end else begin : g_pass
            assign n_ctx[k] = r_ctx[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < TOT; k++) begin
                r_ctx[k] <= n_ctx[k];
            end
        end
    end

    // azimuth pair, folded into the right half plane
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0 <= in_xneg ? -in_x : in_x;
            r_b0 <= in_xneg ? in_y : -in_y;
        end
    end

    assign c1_a[0] = r_a0;
    assign c1_b[0] = r_b0;
    assign c1_u[0] = '0;
    assign c1_v[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_c1
        vrd_cordic_step #(.SHIFT(i), .USE_DIR(1'b0)) u_step (
            .i_clk (i_clk), .i_en (en),
            .i_a (c1_a[i]), .i_b (c1_b[i]), .i_u (c1_u[i]), .i_v (c1_v[i]),
            .i_dir (1'b0),
            .o_a (c1_a[i+1]), .o_b (c1_b[i+1]), .o_u (c1_u[i+1]), .o_v (c1_v[i+1])
        );
    end

    vrd_unscale u_unscale_r (.i_clk (i_clk), .i_en (en), .i_val (c1_a[N]), .o_val (u1_r));

    // tilt pair (|z|, sign(z)*r)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_a <= r_ctx[P2-1].zabs;
            r_p2_b <= r_ctx[P2-1].zneg ? -u1_r : u1_r;
            r_p2_u <= r_ctx[P2-1].px;
            r_p2_v <= r_ctx[P2-1].pz;
        end
    end

    assign c2_a[0] = r_p2_a;
    assign c2_b[0] = r_p2_b;
    assign c2_u[0] = r_p2_u;
    assign c2_v[0] = r_p2_v;

    for (genvar i = 0; i < N; i++) begin : g_c2
        vrd_cordic_step #(.SHIFT(i), .USE_DIR(1'b0)) u_step (
            .i_clk (i_clk), .i_en (en),
            .i_a (c2_a[i]), .i_b (c2_b[i]), .i_u (c2_u[i]), .i_v (c2_v[i]),
            .i_dir (1'b0),
            .o_a (c2_a[i+1]), .o_b (c2_b[i+1]), .o_u (c2_u[i+1]), .o_v (c2_v[i+1])
        );
    end

    vrd_unscale u_unscale_px1 (.i_clk (i_clk), .i_en (en), .i_val (c2_u[N]), .o_val (u2_u));
    vrd_unscale u_unscale_pzr (.i_clk (i_clk), .i_en (en), .i_val (c2_v[N]), .o_val (u2_v));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_u <= r_ctx[P3-1].xneg ? -u2_u : u2_u;
            r_p3_v <= r_ctx[P3-1].xneg ? -r_ctx[P3-1].py : r_ctx[P3-1].py;
        end
    end

    assign c3_a[0] = '0;
    assign c3_b[0] = '0;
    assign c3_u[0] = r_p3_u;
    assign c3_v[0] = r_p3_v;

    // azimuth rotation replays the directions found in the first pass
    for (genvar i = 0; i < N; i++) begin : g_c3
        vrd_cordic_step #(.SHIFT(i), .USE_DIR(1'b1)) u_step (
            .i_clk (i_clk), .i_en (en),
            .i_a (c3_a[i]), .i_b (c3_b[i]), .i_u (c3_u[i]), .i_v (c3_v[i]),
            .i_dir (r_ctx[P3+i].dirs[i]),
            .o_a (c3_a[i+1]), .o_b (c3_b[i+1]), .o_u (c3_u[i+1]), .o_v (c3_v[i+1])
        );
    end

    vrd_unscale u_unscale_rx (.i_clk (i_clk), .i_en (en), .i_val (c3_u[N]), .o_val (u3_u));
    vrd_unscale u_unscale_ry (.i_clk (i_clk), .i_en (en), .i_val (c3_v[N]), .o_val (u3_v));

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_ctx[TOT-2].axis) begin
                r_out <= OUT_W'({f_narrow(r_ctx[TOT-2].pz), f_narrow(r_ctx[TOT-2].py),
                                 f_narrow(r_ctx[TOT-2].px)});
            end else begin
                r_out <= OUT_W'({f_narrow(r_ctx[TOT-2].pzr), f_narrow(u3_v),
                                 f_narrow(u3_u)});
            end
        end
    end

    assign o_m_tvalid = r_vld[TOT-1];
    assign o_m_tdata  = r_out;

    `VRD_ASSERT_NOW(a_ready_only_on_stall, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready, "ready low without output stall")
    `VRD_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_vld[0], "accepted transaction not in first stage")
    `VRD_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, !o_s_tready, $stable(r_vld), "pipeline moved during stall")
endmodule

// ----- bench/vrd_checker.sv -----
// Checker for the vector rotate-to-direction core: predicts rotated vectors and compares.
module vrd_checker #(
    parameter int DATA_WIDTH   = 32,
    parameter int CORDIC_STEPS = 20,
    parameter int IN_W         = 192,
    parameter int OUT_W        = 96
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_pending
);
    localparam int GUARD = 60 - DATA_WIDTH;
    localparam longint unsigned GAIN_INV = 64'd652032874;

    typedef struct {
        logic [DATA_WIDTH-1:0] rx;
        logic [DATA_WIDTH-1:0] ry;
        logic [DATA_WIDTH-1:0] rz;
    } t_rotated;

    t_rotated rotated_q[$];

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sext(logic [DATA_WIDTH-1:0] f);
        logic signed [DATA_WIDTH-1:0] sf;
        sf = f;
        return longint'(sf);
    endfunction

    function automatic longint gain_fix(longint v);
        longint unsigned m, hi, lo, p;
        m  = (v < 0) ? longint'(-v) : v;
        hi = m >> 32;
        lo = m & 64'hFFFF_FFFF;
        p  = ((hi * GAIN_INV) << 2) + ((lo * GAIN_INV + (64'd1 << 29)) >> 30);
        return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    // vectoring on (a,b) while rotating (u,v) alongside; returns final a
    function automatic longint rotate_pair(longint a, longint b, inout longint u,
                                           inout longint v);
        longint sa, sb, su, sv;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            sa = asr(a, i); sb = asr(b, i); su = asr(u, i); sv = asr(v, i);
            if (b >= 0) begin
                a += sb; b -= sa; u += sv; v -= su;
            end else begin
                a -= sb; b += sa; u -= sv; v += su;
            end
        end
        return a;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] to_field(longint v);
        longint q, hi, lo;
        hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        q  = (v + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q[DATA_WIDTH-1:0];
    endfunction

    function automatic t_rotated predict_rotation(logic [IN_W-1:0] d);
        t_rotated res;
        longint x, y, z, px, py, pz, dx, dy, dz, ax, bx, du, dv, mag, r, u, v, px1, pzr;
        x  = sext(d[0*DATA_WIDTH +: DATA_WIDTH]);
        y  = sext(d[1*DATA_WIDTH +: DATA_WIDTH]);
        z  = sext(d[2*DATA_WIDTH +: DATA_WIDTH]);
        px = sext(d[3*DATA_WIDTH +: DATA_WIDTH]) <<< GUARD;
        py = sext(d[4*DATA_WIDTH +: DATA_WIDTH]) <<< GUARD;
        pz = sext(d[5*DATA_WIDTH +: DATA_WIDTH]) <<< GUARD;
        if (x == 0 && y == 0) begin
            res.rx = to_field(px); res.ry = to_field(py); res.rz = to_field(pz);
            return res;
        end
        dx = x <<< GUARD; dy = y <<< GUARD; dz = z <<< GUARD;
        ax = x < 0 ? -dx : dx;
        bx = x < 0 ? dy : -dy;
        du = 0; dv = 0;
        mag = rotate_pair(ax, bx, du, dv);
        r = gain_fix(mag);
        u = px; v = pz;
        mag = rotate_pair(dz < 0 ? -dz : dz, dz < 0 ? -r : r, u, v);
        px1 = gain_fix(u);
        pzr = gain_fix(v);
        u = px1; v = py;
        if (x < 0) begin
            u = -u; v = -v;
        end
        mag = rotate_pair(ax, bx, u, v);
        res.rx = to_field(gain_fix(u));
        res.ry = to_field(gain_fix(v));
        res.rz = to_field(pzr);
        return res;
    endfunction

    assign o_pending = rotated_q.size();

    always @(posedge i_clk) begin
        t_rotated exp_r;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                rotated_q.insert(rotated_q.size(), predict_rotation(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (rotated_q.size() == 0) begin
                    $error("unexpected transaction %h", i_m_tdata);
                    errs = errs + 1;
                end else begin
                    exp_r = rotated_q.pop_front();
                    if (i_m_tdata[0 +: DATA_WIDTH] !== exp_r.rx) begin
                        $error("rot_x expected %h actual %h", exp_r.rx,
                               i_m_tdata[0 +: DATA_WIDTH]);
                        errs = errs + 1;
                    end
                    if (i_m_tdata[DATA_WIDTH +: DATA_WIDTH] !== exp_r.ry) begin
                        $error("rot_y expected %h actual %h", exp_r.ry,
                               i_m_tdata[DATA_WIDTH +: DATA_WIDTH]);
                        errs = errs + 1;
                    end
                    if (i_m_tdata[2*DATA_WIDTH +: DATA_WIDTH] !== exp_r.rz) begin
                        $error("rot_z expected %h actual %h", exp_r.rz,
                               i_m_tdata[2*DATA_WIDTH +: DATA_WIDTH]);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

// ----- bench/testbench.sv -----
// Testbench top: stimulus, stalls and verdict for the vector rotate-to-direction core.
module testbench;
    localparam int DW    = 32;
    localparam int STEPS = 20;
    localparam int IN_W  = 6 * DW;
    localparam int OUT_W = 3 * DW;
    localparam int LATENCY = 3 * STEPS + 13;
    localparam int IDLE_LIMIT = 5000;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;
    int               send_idle_pct;
    int               sink_stall_pct;
    int               hold_cycles;
    int               quiet_cycles;

    vector_rotate_to_direction_core #(.DATA_WIDTH(DW), .CORDIC_STEPS(STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    vrd_checker #(.DATA_WIDTH(DW), .CORDIC_STEPS(STEPS), .IN_W(IN_W), .OUT_W(OUT_W)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DW-1:0] rand_field();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(DW-1){1'b1}}};
            1: return {1'b1, {(DW-1){1'b0}}};
            2: return '0;
            3: return DW'($urandom_range(0, 1) ? 65536 : -65536);
            4: return DW'(int'($urandom_range(0, 2000000)) - 1000000);
            default: return DW'($urandom());
        endcase
    endfunction

    // sink side: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // watchdog on accepted transactions
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [IN_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pack_item(logic [DW-1:0] x, y, z, px, py, pz);
        return {pz, py, px, z, y, x};
    endfunction

    initial begin
        logic [DW-1:0] mx, mn, one;
        mx = {1'b0, {(DW-1){1'b1}}};
        mn = {1'b1, {(DW-1){1'b0}}};
        one = DW'(65536);
        i_rst_n = 0; s_tvalid = 0; s_tdata = '0; m_tready = 0;
        send_idle_pct = 0; sink_stall_pct = 0; hold_cycles = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: axis cases, zero tilt, horizontal direction, extremes
        send_item(pack_item(0, 0, 0, one, one, one));
        send_item(pack_item(0, 0, mn, mx, mn, mx));
        send_item(pack_item(0, 0, one, mn, mx, mn));
        send_item(pack_item(one, 0, 0, one, 0, one));
        send_item(pack_item(0, one, 0, one, one, 0));
        send_item(pack_item(-one, 0, one, one, one, one));
        send_item(pack_item(0, -one, -one, one, -one, one));
        send_item(pack_item(one, one, one, one, 0, 0));
        send_item(pack_item(mx, mx, mx, mx, mx, mx));
        send_item(pack_item(mn, mn, mn, mn, mn, mn));
        send_item(pack_item(mx, mn, 0, mn, mx, mn));
        send_item(pack_item(mn, mx, mx, mx, mn, mx));
        send_item(pack_item(-one, -one, -one, '1, '1, '1));
        send_item(pack_item(1, 0, -1, 1, 1, 1));
        send_item(pack_item(-1, 1, 0, mx, mx, mn));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 78; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 78; end
                3: begin send_idle_pct = 27; sink_stall_pct = 27; end
                default: begin send_idle_pct = 0; sink_stall_pct = 0;
                    hold_cycles = 300; end
            endcase
            for (int n = 0; n < 170; n++)
                send_item(pack_item(rand_field(), rand_field(), rand_field(),
                                    rand_field(), rand_field(), rand_field()));
        end
        s_tvalid <= 1'b0;
        sink_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
